[hw/rtl/hder_pkg.sv]
// shared constants, types and codes of the hit-density eviction ranker
package hder_pkg;

  // default histogram size
  localparam int unsigned DefNumBins = 1024;

  // register reset values
  localparam logic [19:0] BinStartRst      = 20'd128;
  localparam logic [4:0]  BinWidthLog2Rst  = 5'd7;
  localparam logic [31:0] RebuildPeriodRst = 32'd100000;

  // shared multiplier operand width
  localparam int unsigned MulW = 32;

  // divider: quotient bits plus one overflow bit, wide remainder
  localparam int unsigned QuoW     = 32;
  localparam int unsigned DivSteps = QuoW + 1;
  localparam int unsigned DivW     = 128;

  // item opcodes
  typedef enum logic [1:0] {
    OpInsert  = 2'd0,
    OpHit     = 2'd1,
    OpEvict   = 2'd2,
    OpCompare = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgBinStart      = 2'd0,
    CfgBinWidthLog2  = 2'd1,
    CfgRebuildPeriod = 2'd2
  } cfg_idx_e;

endpackage

[hw/rtl/hder_mul.sv]
// shared 32x32 multiplier with registered product
module hder_mul (
  input  logic                           clk_i,
  input  logic [hder_pkg::MulW-1:0]      a_i,
  input  logic [hder_pkg::MulW-1:0]      b_i,
  output logic [2*hder_pkg::MulW-1:0]    p_o
);

  logic [2*hder_pkg::MulW-1:0] p_q;

  // one product per cycle, product registered
  always_ff @(posedge clk_i) begin
    p_q <= (2*hder_pkg::MulW)'(a_i) * (2*hder_pkg::MulW)'(b_i);
  end

  assign p_o = p_q;

endmodule

[hw/rtl/hder_div.sv]
// restoring divider, one quotient bit per cycle, saturating on overflow
module hder_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hder_pkg::DivW-1:0]   num_i,
  input  logic [hder_pkg::DivW-1:0]   den_i,
  output logic                        done_o,
  output logic [hder_pkg::QuoW-1:0]   quo_o
);

  localparam int unsigned CntW = $clog2(hder_pkg::DivSteps);
  localparam logic [CntW-1:0] LastCnt = CntW'(hder_pkg::DivSteps - 1);

  logic [hder_pkg::DivW-1:0]     rem_q;
  logic [hder_pkg::DivW-1:0]     dvs_q;
  logic [hder_pkg::DivSteps-1:0] quo_q;
  logic [CntW-1:0]               cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic                          ge;

  assign ge = (rem_q >= dvs_q);

  // step counter and handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // compare, subtract and shift the divisor down
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dvs_q <= den_i;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dvs_q;
      end
      dvs_q <= dvs_q >> 1;
      quo_q <= {quo_q[hder_pkg::DivSteps-2:0], ge};
    end
  end

  // top bit set means the quotient does not fit (or divisor zero)
  assign done_o = done_q;
  assign quo_o  = quo_q[hder_pkg::DivSteps-1] ? '1 : quo_q[hder_pkg::QuoW-1:0];

endmodule

[hw/rtl/hit_density_eviction_ranker.sv]
// Hit-density eviction ranker. Inserts, hits and evictions update hit and
// lifetime age histograms held in single-port memories; a compare returns the
// item of lower hit density per unit size, first rebuilding the rank table
// when the rebuild period has elapsed. After reset a clearing pass zeroes
// every bin of all three memories while input stays stalled. An insert, hit
// or evict is one read-modify-write of the histogram memory: a read in the
// dispatch state, a write in the update state, then ready again. A compare
// without rebuild makes two rank table reads and two products on the shared
// multiplier. A rebuild walks the bins from the top down, per bin adding to
// the running sums and expected lifetime, forming four partial products on
// the shared multiplier and running the bit-serial divider; the bin below
// the top reuses its sums. Configuration writes are always taken.
module hit_density_eviction_ranker #(
  parameter int unsigned NUM_BINS = hder_pkg::DefNumBins
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] now_i,
  input  logic [31:0] last_access_a_i,
  input  logic [31:0] size_a_i,
  input  logic [31:0] last_access_b_i,
  input  logic [31:0] size_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        victim_is_second_o,
  output logic        table_rebuilt_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(NUM_BINS);
  localparam logic [AW-1:0] LastBin  = AW'(NUM_BINS - 1);
  localparam logic [31:0]   LastBinW = 32'(NUM_BINS - 1);

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_DISP   = 13'b0000000000100,
    S_UPD    = 13'b0000000001000,
    S_CHK    = 13'b0000000010000,
    S_RB_ACC = 13'b0000000100000,
    S_RB_EXP = 13'b0000001000000,
    S_RB_MUL = 13'b0000010000000,
    S_RB_DIV = 13'b0000100000000,
    S_LK_A   = 13'b0001000000000,
    S_LK_B   = 13'b0010000000000,
    S_LK_M   = 13'b0100000000000,
    S_RES    = 13'b1000000000000
  } state_e;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

  // age to histogram bin
  function automatic logic [AW-1:0] bin_of(input logic [31:0] age,
                                           input logic [19:0] start,
                                           input logic [4:0]  sh);
    logic [31:0] d;
    d = (age - {12'd0, start}) >> sh;
    if (age < {12'd0, start}) begin
      return '0;
    end
    if (d >= LastBinW) begin
      return LastBin;
    end
    return AW'(d + 32'd1);
  endfunction

  state_e state_q, state_d;

  // item and configuration
  hder_pkg::op_e op_q;
  logic [31:0] now_q, la_q, sa_q, lb_q, sb_q;
  logic [19:0] bin_start_q;
  logic [4:0]  bwl_q;
  logic [31:0] period_q;

  // persistent counters
  logic [31:0] hit_total_q, life_total_q, last_rb_q;
  logic        rebuilt_q;

  // sequencer working registers
  logic [AW-1:0] idx_q, bin_q;
  logic [63:0]   acc_hit_q, acc_life_q, exp_q;
  logic [95:0]   num_q, den_q;
  logic [2:0]    mph_q;
  logic [31:0]   rank_a_q, rank_b_q;
  logic [63:0]   lhs_q;
  logic          victim_pend_q;

  // result register
  logic out_valid_q, victim_q, out_rebuilt_q;

  // memories
  logic [31:0] hit_mem  [NUM_BINS];
  logic [31:0] life_mem [NUM_BINS];
  logic [31:0] rank_mem [NUM_BINS];
  logic [31:0] hit_rd_q, life_rd_q, rank_rd_q;

  logic [AW-1:0] hist_addr, rank_addr, bin_cur;
  logic          hist_rd_en, hit_we, life_we, rank_rd_en, rank_we;
  logic [31:0]   hit_wdata, life_wdata, rank_wdata;
  logic [31:0]   sel_la;

  logic [hder_pkg::MulW-1:0]   mul_a, mul_b;
  logic [2*hder_pkg::MulW-1:0] mul_p;
  logic                        div_start, div_done;
  logic [hder_pkg::QuoW-1:0]   div_quo;
  logic                        rebuild_due, out_load;

  // shared bin unit: second item only during its lookup
  assign sel_la  = (state_q == S_LK_B) ? lb_q : la_q;
  assign bin_cur = bin_of(now_q - sel_la, bin_start_q, bwl_q);

  assign rebuild_due = ((now_q - last_rb_q) > period_q);
  assign out_load    = (state_q == S_RES) && (!out_valid_q || !out_stall_i);

  // memory port control
  always_comb begin
    hist_addr  = '0;
    hist_rd_en = 1'b0;
    hit_we     = 1'b0;
    life_we    = 1'b0;
    hit_wdata  = '0;
    life_wdata = '0;
    rank_addr  = '0;
    rank_rd_en = 1'b0;
    rank_we    = 1'b0;
    rank_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        hist_addr = idx_q;
        hit_we    = 1'b1;
        life_we   = 1'b1;
        rank_addr = idx_q;
        rank_we   = 1'b1;
      end
      S_DISP: begin
        hist_addr  = (op_q == hder_pkg::OpInsert) ? LastBin : bin_cur;
        hist_rd_en = 1'b1;
      end
      S_UPD: begin
        hist_addr  = bin_q;
        hit_we     = (op_q != hder_pkg::OpEvict);
        life_we    = 1'b1;
        hit_wdata  = sat_inc(hit_rd_q);
        life_wdata = sat_inc(life_rd_q);
      end
      S_CHK: begin
        hist_addr  = LastBin;
        hist_rd_en = 1'b1;
      end
      S_RB_DIV: begin
        if (div_done) begin
          rank_addr  = idx_q;
          rank_we    = 1'b1;
          rank_wdata = div_quo;
          hist_addr  = idx_q;
          hist_rd_en = 1'b1;
        end
      end
      S_LK_A, S_LK_B: begin
        rank_addr  = bin_cur;
        rank_rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // histogram memories
  always_ff @(posedge clk_i) begin
    if (hit_we) begin
      hit_mem[hist_addr] <= hit_wdata;
    end
    if (hist_rd_en) begin
      hit_rd_q <= hit_mem[hist_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (life_we) begin
      life_mem[hist_addr] <= life_wdata;
    end
    if (hist_rd_en) begin
      life_rd_q <= life_mem[hist_addr];
    end
  end

  // rank table memory
  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rank_addr] <= rank_wdata;
    end
    if (rank_rd_en) begin
      rank_rd_q <= rank_mem[rank_addr];
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_RB_MUL: begin
        case (mph_q)
          3'd0: begin
            mul_a = acc_hit_q[31:0];
            mul_b = life_total_q;
          end
          3'd1: begin
            mul_a = acc_hit_q[63:32];
            mul_b = life_total_q;
          end
          3'd2: begin
            mul_a = exp_q[31:0];
            mul_b = hit_total_q;
          end
          default: begin
            mul_a = exp_q[63:32];
            mul_b = hit_total_q;
          end
        endcase
      end
      S_LK_M: begin
        if (mph_q == 3'd0) begin
          mul_a = rank_a_q;
          mul_b = sb_q;
        end else begin
          mul_a = rank_b_q;
          mul_b = sa_q;
        end
      end
      default: begin
      end
    endcase
  end

  hder_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // density: (hits * lifetime total) << 16 over (hit total * expected life)
  assign div_start = (state_q == S_RB_MUL) && (mph_q == 3'd5);

  hder_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({16'd0, num_q, 16'd0}),
    .den_i   ({den_q, 32'd0}),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (idx_q == LastBin) state_d = S_IDLE;
      S_IDLE:   if (in_valid_i) state_d = S_DISP;
      S_DISP:   state_d = (op_q == hder_pkg::OpCompare) ? S_CHK : S_UPD;
      S_UPD:    state_d = S_IDLE;
      S_CHK:    state_d = rebuild_due ? S_RB_ACC : S_LK_A;
      S_RB_ACC: state_d = S_RB_EXP;
      S_RB_EXP: state_d = S_RB_MUL;
      S_RB_MUL: if (mph_q == 3'd5) state_d = S_RB_DIV;
      S_RB_DIV: begin
        if (div_done) begin
          if (idx_q == '0) begin
            state_d = S_LK_A;
          end else if (idx_q == LastBin) begin
            state_d = S_RB_MUL;
          end else begin
            state_d = S_RB_ACC;
          end
        end
      end
      S_LK_A:   state_d = S_LK_B;
      S_LK_B:   state_d = S_LK_M;
      S_LK_M:   if (mph_q == 3'd2) state_d = S_RES;
      S_RES:    if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control state, configuration and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      idx_q        <= '0;
      mph_q        <= '0;
      bin_start_q  <= hder_pkg::BinStartRst;
      bwl_q        <= hder_pkg::BinWidthLog2Rst;
      period_q     <= hder_pkg::RebuildPeriodRst;
      hit_total_q  <= '0;
      life_total_q <= '0;
      last_rb_q    <= '0;
      rebuilt_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // register writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          hder_pkg::CfgBinStart:      bin_start_q <= cfg_data_i[19:0];
          hder_pkg::CfgBinWidthLog2:  bwl_q       <= cfg_data_i[4:0];
          hder_pkg::CfgRebuildPeriod: period_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // result register
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: idx_q <= idx_q + 1'b1;
        S_UPD: begin
          if (op_q != hder_pkg::OpEvict) begin
            hit_total_q <= sat_inc(hit_total_q);
          end
          life_total_q <= sat_inc(life_total_q);
        end
        S_CHK: begin
          rebuilt_q <= rebuild_due;
          if (rebuild_due) begin
            last_rb_q <= now_q;
            idx_q     <= LastBin;
          end
        end
        S_RB_MUL: mph_q <= (mph_q == 3'd5) ? 3'd0 : mph_q + 3'd1;
        S_RB_DIV: if (div_done && idx_q != '0) idx_q <= idx_q - 1'b1;
        S_LK_M:   mph_q <= (mph_q == 3'd2) ? 3'd0 : mph_q + 3'd1;
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q <= hder_pkg::op_e'(opcode_i);
      now_q <= now_i;
      la_q  <= last_access_a_i;
      sa_q  <= size_a_i;
      lb_q  <= last_access_b_i;
      sb_q  <= size_b_i;
    end
    if (out_load) begin
      victim_q      <= victim_pend_q;
      out_rebuilt_q <= rebuilt_q;
    end
    case (state_q)
      S_DISP: bin_q <= hist_addr;
      S_CHK: begin
        acc_hit_q  <= '0;
        acc_life_q <= '0;
        exp_q      <= '0;
      end
      // running suffix sums of one bin
      S_RB_ACC: begin
        acc_hit_q  <= acc_hit_q + {32'd0, hit_rd_q};
        acc_life_q <= acc_life_q + {32'd0, life_rd_q};
      end
      // expected lifetime, saturating
      S_RB_EXP: exp_q <= (exp_q > ~acc_life_q) ? '1 : exp_q + acc_life_q;
      // assemble the two 96-bit products from partial products
      S_RB_MUL: begin
        case (mph_q)
          3'd1: num_q <= {32'd0, mul_p};
          3'd2: num_q <= num_q + {mul_p, 32'd0};
          3'd3: den_q <= {32'd0, mul_p};
          3'd4: den_q <= den_q + {mul_p, 32'd0};
          default: begin
          end
        endcase
      end
      S_LK_B: rank_a_q <= rank_rd_q;
      // cross-multiplied densities, tie goes to the first item
      S_LK_M: begin
        case (mph_q)
          3'd0: rank_b_q <= rank_rd_q;
          3'd1: lhs_q    <= mul_p;
          default: victim_pend_q <= (lhs_q > mul_p);
        endcase
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign victim_is_second_o = victim_q;
  assign table_rebuilt_o    = out_rebuilt_q;
  assign cfg_ready_o        = 1'b1;

endmodule

[hw/rtl/hder_chk.sv]
// port-level checker for the hit-density eviction ranker, with its bind
module hder_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        victim_is_second_o,
  input logic        table_rebuilt_o
);

  // one item at a time: a taken beat closes the input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input open right after an accepted beat");

  // a result finishes its item, the block is ready again
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result shown while the item is still in work");

  // stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped under stall");

  // stalled payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(victim_is_second_o) && $stable(table_rebuilt_o)))
    else $error("result payload changed under stall");

endmodule

bind hit_density_eviction_ranker hder_chk u_hder_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .victim_is_second_o (victim_is_second_o),
  .table_rebuilt_o    (table_rebuilt_o)
);

[dv/tb_hit_density_eviction_ranker.sv]
// self-checking testbench for the hit-density eviction ranker
`timescale 1ns / 1ps

module tb_hit_density_eviction_ranker;

  localparam int unsigned NBins     = hder_pkg::DefNumBins;
  localparam int unsigned IdleLimit = 200000;
  localparam int unsigned DrainCyc  = 20;
  localparam logic [31:0] Sat32     = 32'hFFFF_FFFF;

  typedef struct packed {
    hder_pkg::op_e op;
    logic [31:0]   now;
    logic [31:0]   la;
    logic [31:0]   sa;
    logic [31:0]   lb;
    logic [31:0]   sb;
  } access_t;

  typedef struct packed {
    logic victim;
    logic rebuilt;
  } verdict_t;

  typedef struct packed {
    access_t  acc;
    logic     typed;
    verdict_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = hder_pkg::OpInsert;
  logic [31:0] now_i = '0;
  logic [31:0] last_access_a_i = '0;
  logic [31:0] size_a_i = 32'd1;
  logic [31:0] last_access_b_i = '0;
  logic [31:0] size_b_i = 32'd1;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        victim_is_second_o;
  logic        table_rebuilt_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = hder_pkg::CfgBinStart;
  logic [31:0] cfg_data_i = '0;

  hit_density_eviction_ranker uut (.*);

  // predictor state
  logic [31:0] hit_hist [NBins];
  logic [31:0] life_hist [NBins];
  logic [31:0] rank_lut [NBins];
  logic [31:0] hits_sum, life_sum, last_rebuild;
  logic [19:0] cfg_start;
  logic [4:0]  cfg_shift;
  logic [31:0] cfg_period;

  verdict_t    verdict_q [$];
  int unsigned errors = 0;
  int unsigned idle_cyc = 0;
  bit          quiet = 1'b0;
  logic [31:0] tbase;
  int unsigned cmp_pct;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit idle_roll();
    return !quiet && ($urandom_range(0, 99) < 38);
  endfunction

  function automatic int unsigned age_bin(logic [31:0] age);
    logic [31:0] d;
    if (age < {12'b0, cfg_start}) return 0;
    d = (age - {12'b0, cfg_start}) >> cfg_shift;
    if (d >= NBins - 1) return NBins - 1;
    return d + 32'd1;
  endfunction

  // Q16.16 suffix hit share over expected lifetime
  function automatic logic [31:0] hit_density(logic [63:0] acc_hit, logic [63:0] exp_life);
    logic [127:0] num, den;
    num = ({64'b0, acc_hit} * {96'b0, life_sum}) << 16;
    den = {96'b0, hits_sum} * {64'b0, exp_life};
    if (den == '0) return Sat32;
    if (num >= (den << 32)) return Sat32;
    return 32'(num / den);
  endfunction

  function automatic void rebuild_ranks();
    logic [63:0] acc_hit, acc_life, exp_life;
    acc_hit  = {32'b0, hit_hist[NBins-1]};
    acc_life = {32'b0, life_hist[NBins-1]};
    exp_life = acc_life;
    rank_lut[NBins-1] = hit_density(acc_hit, exp_life);
    for (int i = NBins - 2; i >= 0; i--) begin
      rank_lut[i] = hit_density(acc_hit, exp_life);
      acc_hit  += {32'b0, hit_hist[i]};
      acc_life += {32'b0, life_hist[i]};
      exp_life = (exp_life > ~64'd0 - acc_life) ? ~64'd0 : exp_life + acc_life;
    end
  endfunction

  function automatic void bump(ref logic [31:0] c);
    if (c != Sat32) c++;
  endfunction

  // update model state; returns 1 when a verdict is produced
  function automatic bit rank_access(access_t a, output verdict_t v);
    int unsigned b;
    logic [63:0] lhs, rhs;
    v = '0;
    case (a.op)
      hder_pkg::OpInsert: begin
        bump(hit_hist[NBins-1]);
        bump(hits_sum);
        bump(life_hist[NBins-1]);
        bump(life_sum);
        return 1'b0;
      end
      hder_pkg::OpHit, hder_pkg::OpEvict: begin
        b = age_bin(a.now - a.la);
        if (a.op == hder_pkg::OpHit) begin
          bump(hit_hist[b]);
          bump(hits_sum);
        end
        bump(life_hist[b]);
        bump(life_sum);
        return 1'b0;
      end
      default: begin
        if ((a.now - last_rebuild) > cfg_period) begin
          last_rebuild = a.now;
          rebuild_ranks();
          v.rebuilt = 1'b1;
        end
        lhs = {32'b0, rank_lut[age_bin(a.now - a.la)]} * {32'b0, a.sb};
        rhs = {32'b0, rank_lut[age_bin(a.now - a.lb)]} * {32'b0, a.sa};
        v.victim = (lhs <= rhs) ? 1'b0 : 1'b1;
        return 1'b1;
      end
    endcase
  endfunction

  // drive one beat and wait for it to be taken
  task automatic send_access(access_t a, bit typed, verdict_t want);
    verdict_t v;
    while (idle_roll()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    opcode_i        <= a.op;
    now_i           <= a.now;
    last_access_a_i <= a.la;
    size_a_i        <= a.sa;
    last_access_b_i <= a.lb;
    size_b_i        <= a.sb;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (rank_access(a, v)) verdict_q.push_back(typed ? want : v);
  endtask

  // one register write, with the channel dropped to idle afterwards
  task automatic write_reg(hder_pkg::cfg_idx_e idx, logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      hder_pkg::CfgBinStart:     cfg_start = data[19:0];
      hder_pkg::CfgBinWidthLog2: cfg_shift = data[4:0];
      default:                   cfg_period = data;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_age();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return {12'b0, cfg_start} + $urandom_range(0, 3) - 32'd1;
      2: return {12'b0, cfg_start} + ($urandom_range(0, NBins) << cfg_shift);
      3: return {12'b0, cfg_start} + $urandom_range(0, 32'h3FFF);
      4: return Sat32 - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    logic [31:0] s;
    case ($urandom_range(0, 3))
      0: s = $urandom_range(1, 4);
      1: s = Sat32;
      default: s = $urandom;
    endcase
    return (s == '0) ? 32'd1 : s;
  endfunction

  task automatic random_phase(int unsigned n);
    access_t a;
    verdict_t none;
    none = '0;
    tbase = $urandom;
    for (int unsigned k = 0; k < n; k++) begin
      quiet = (k >= n / 3) && (k < n / 2);
      tbase += $urandom_range(0, 50);
      if ($urandom_range(0, 99) < cmp_pct) a.op = hder_pkg::OpCompare;
      else a.op = hder_pkg::op_e'($urandom_range(0, 2));
      a.now = tbase;
      a.la  = tbase - pick_age();
      a.lb  = tbase - pick_age();
      a.sa  = pick_size();
      a.sb  = pick_size();
      send_access(a, 1'b0, none);
    end
    quiet = 1'b0;
    drain();
  endtask

  // directed stimulus at the reset register values
  row_t dir_rows [14] = '{
    // idle table after reset: all ranks zero, tie
    '{'{hder_pkg::OpCompare, 32'd0, 32'd0, 32'd1, 32'd0, 32'd1}, 1'b1, '{1'b0, 1'b0}},
    // period elapsed with empty histograms: every rank saturates
    '{'{hder_pkg::OpCompare, 32'd100001, 32'd100001, 32'd1, 32'd100001, 32'd2}, 1'b1,
      '{1'b1, 1'b1}},
    '{'{hder_pkg::OpInsert,  32'd100010, 32'd0, 32'd1, 32'd0, 32'd1}, 1'b0, '{1'b0, 1'b0}},
    '{'{hder_pkg::OpHit,     32'd100010, 32'd100010, 32'd1, 32'd0, 32'd1}, 1'b0,
      '{1'b0, 1'b0}},
    '{'{hder_pkg::OpHit,     32'd100010, 32'd100009, 32'd1, 32'd0, 32'd1}, 1'b0,
      '{1'b0, 1'b0}},
    '{'{hder_pkg::OpHit,     32'd100010, 32'd99883, 32'd1, 32'd0, 32'd1}, 1'b0,
      '{1'b0, 1'b0}},
    '{'{hder_pkg::OpHit,     32'd100010, 32'd99882, 32'd1, 32'd0, 32'd1}, 1'b0,
      '{1'b0, 1'b0}},
    // age wraps to the maximum
    '{'{hder_pkg::OpHit,     32'd100010, 32'd100011, 32'd1, 32'd0, 32'd1}, 1'b0,
      '{1'b0, 1'b0}},
    '{'{hder_pkg::OpEvict,   32'd100010, 32'd99881, 32'd1, 32'd0, 32'd1}, 1'b0,
      '{1'b0, 1'b0}},
    // age past the last bin clamps
    '{'{hder_pkg::OpEvict,   32'd300000, 32'd0, 32'd1, 32'd0, 32'd1}, 1'b0, '{1'b0, 1'b0}},
    '{'{hder_pkg::OpHit,     32'd5, Sat32, Sat32, Sat32, Sat32}, 1'b0, '{1'b0, 1'b0}},
    '{'{hder_pkg::OpCompare, 32'd300000, 32'd299900, Sat32, 32'd0, 32'd1}, 1'b0,
      '{1'b0, 1'b0}},
    // same bin, same size: a tie names the first item as victim
    '{'{hder_pkg::OpCompare, 32'd300001, 32'd300001, 32'd7, 32'd300001, 32'd7}, 1'b1,
      '{1'b0, 1'b0}},
    '{'{hder_pkg::OpCompare, Sat32, 32'd299000, Sat32, Sat32, Sat32}, 1'b0, '{1'b0, 1'b0}}
  };

  // result check, output stall and watchdog
  always @(posedge clk_i) begin
    verdict_t want;
    bit moved;
    moved = (in_valid_i && !in_stall_o) || (cfg_valid_i && cfg_ready_o);
    if (out_valid_o && !out_stall_i) begin
      moved = 1'b1;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected beat victim=%0b rebuilt=%0b", $time,
                 victim_is_second_o, table_rebuilt_o);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (victim_is_second_o !== want.victim) begin
          $display("%0t: victim_is_second expected %0b actual %0b", $time,
                   want.victim, victim_is_second_o);
          errors++;
        end
        if (table_rebuilt_o !== want.rebuilt) begin
          $display("%0t: table_rebuilt expected %0b actual %0b", $time,
                   want.rebuilt, table_rebuilt_o);
          errors++;
        end
      end
    end
    out_stall_i <= idle_roll();
    idle_cyc = moved ? 0 : idle_cyc + 1;
    if (idle_cyc >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // main sequence
  initial begin
    for (int i = 0; i < NBins; i++) begin
      hit_hist[i]  = '0;
      life_hist[i] = '0;
      rank_lut[i]  = '0;
    end
    hits_sum     = '0;
    life_sum     = '0;
    last_rebuild = '0;
    cfg_start    = hder_pkg::BinStartRst;
    cfg_shift    = hder_pkg::BinWidthLog2Rst;
    cfg_period   = hder_pkg::RebuildPeriodRst;
    cmp_pct      = 30;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_access(dir_rows[i].acc, dir_rows[i].typed, dir_rows[i].want);
    drain();
    random_phase(150);

    write_reg(hder_pkg::CfgBinStart, 32'd0);
    write_reg(hder_pkg::CfgBinWidthLog2, 32'd0);
    write_reg(hder_pkg::CfgRebuildPeriod, 32'd3000);
    random_phase(200);

    write_reg(hder_pkg::CfgBinStart, 32'hF_FFFF);
    write_reg(hder_pkg::CfgBinWidthLog2, 32'd20);
    write_reg(hder_pkg::CfgRebuildPeriod, Sat32);
    random_phase(200);

    // zero period: rebuild whenever the clock moves, keep it short
    cmp_pct = 20;
    write_reg(hder_pkg::CfgBinStart, 32'd1000);
    write_reg(hder_pkg::CfgBinWidthLog2, 32'd31);
    write_reg(hder_pkg::CfgRebuildPeriod, 32'd0);
    random_phase(20);

    cmp_pct = 30;
    write_reg(hder_pkg::CfgBinStart, {12'b0, 20'($urandom)});
    write_reg(hder_pkg::CfgBinWidthLog2, 32'd3);
    write_reg(hder_pkg::CfgRebuildPeriod, 32'd20000);
    random_phase(170);

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
